@@ sv/rbmc_pkg.sv @@
// rbmc_pkg: shared constants and types for the RGBA8 box-filter mip chain.
// No dependencies; the cell, core and checker files use it by scoped names.
package rbmc_pkg;

    localparam int          MAX_LOG2_WIDTH = 12;
    localparam logic [3:0]  LOG2W_RESET    = 4'd12;
    localparam int          NUM_CH         = 4;
    localparam int          PADDR_W        = 3;
    localparam int          PDATA_W        = 32;

    // register index, taken from paddr[2]
    localparam logic        REG_LOG2_WIDTH = 1'b0;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [NUM_CH-1:0][7:0] pix_t;

    // what one level cell shows the chain controller
    typedef struct packed {
        logic        prod;
        logic [10:0] col;
        logic [10:0] row;
        pix_t        avg;
    } cell_out_t;

endpackage

@@ sv/rbmc_if.sv @@
// rbmc_if: valid/ready channel interfaces for base pixels and tagged results.
// Depends on nothing; used by the top level.
interface rbmc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rbmc_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  level;
    logic [10:0] col;
    logic [10:0] row;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
    logic [7:0]  avg_alpha;
    logic        final_res;

    modport source (output valid, level, col, row, avg_red, avg_green, avg_blue,
                    avg_alpha, final_res, input ready);
    modport sink   (input valid, level, col, row, avg_red, avg_green, avg_blue,
                    avg_alpha, final_res, output ready);
endinterface

@@ sv/rbmc_cell.sv @@
// rbmc_cell: one mip level - position counters, left pixel hold and the
// half-row store of horizontal pair sums. Depends on rbmc_pkg.
module rbmc_cell #(
    parameter int MAXL = rbmc_pkg::MAX_LOG2_WIDTH,
    parameter int S    = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                take,
    input  logic [3:0]          levels,
    input  rbmc_pkg::pix_t      pix,
    output rbmc_pkg::cell_out_t out
);

    localparam int CW    = MAXL - S;
    localparam int AW    = (CW > 2) ? CW - 1 : 1;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = 9 * rbmc_pkg::NUM_CH;

    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [CW-1:0]   row_reg;
    logic [CW-1:0]   row_next;
    logic [CW-1:0]   mask;
    logic [4:0]      span;
    logic            active;
    logic            upd;
    logic [AW-1:0]   addr;
    logic [SW-1:0]   mem [DEPTH];
    logic [SW-1:0]   rd_reg;
    logic [SW-1:0]   wr_data;
    rbmc_pkg::pix_t  hold_reg;
    rbmc_pkg::pix_t  avg;
    logic [rbmc_pkg::NUM_CH-1:0][8:0] pair;
    logic [rbmc_pkg::NUM_CH-1:0][9:0] total;

    assign active = 5'(levels) > 5'(S);
    assign upd    = take && active;
    assign span   = 5'(levels) - 5'(S);
    // side - 1 of this level for the current image
    assign mask   = {CW{1'b1}} >> (5'(CW) - span);
    assign addr   = AW'(col_reg >> 1);

    always_comb
    begin
        for (int i = 0; i < rbmc_pkg::NUM_CH; i++)
        begin
            pair[i]           = {1'b0, hold_reg[i]} + {1'b0, pix[i]};
            total[i]          = {1'b0, rd_reg[i*9 +: 9]} + {1'b0, pair[i]};
            avg[i]            = 8'((total[i] + 10'd2) >> 2);
            wr_data[i*9 +: 9] = pair[i];
        end
    end

    always_comb
    begin
        row_next = row_reg;
        if (col_reg == mask)
        begin
            col_next = '0;
            row_next = (row_reg == mask) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (clr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (upd)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // store read runs every cycle, so the slot is settled before the odd pixel
    // that needs it
    always_ff @(posedge clk)
    begin
        if (upd && !col_reg[0])
            hold_reg <= pix;
        if (upd && col_reg[0] && !row_reg[0])
            mem[addr] <= wr_data;
        rd_reg <= mem[addr];
    end

    assign out.prod = active && col_reg[0] && row_reg[0];
    assign out.col  = 11'(col_reg >> 1);
    assign out.row  = 11'(row_reg >> 1);
    assign out.avg  = avg;

endmodule

@@ sv/rgba8_box_mip_chain_core.sv @@
// rgba8_box_mip_chain_core: streaming 2x2 box-filter mip chain, top level.
// Depends on rbmc_pkg, rbmc_if (rbmc_pix_if, rbmc_res_if) and rbmc_cell.
//
// Usage
//   pix  : base-level RGBA8 pixels in raster order, one transaction each.
//   res  : averaged pixels tagged with level, col and row; final_res marks
//          the last result caused by one base pixel.
//   APB  : register 0 (byte 0) is log2_width, the base side as a power of
//          two and the number of levels built; values above MAX_LOG2_WIDTH
//          act as MAX_LOG2_WIDTH. A write restarts the image at row 0,
//          column 0. Write only while the block is idle.
// Timing
//   Three pixels in four produce nothing and are taken every cycle, even
//   while the result register is held. A pixel that completes a level-1
//   block is taken once earlier results are out; its level-1 result is
//   registered as it is taken, then a wave walks the cell row for deeper
//   levels, one cell per cycle while res is not stalled. Without stalls the
//   rate is close to one pixel per cycle: each cell from level 3 down that a
//   wave reaches holds the next completing pixel back further.
// Reset and stall
//   Reset clears counters and the wave and sets log2_width to 12; the pair
//   sum stores need no clearing. When res is stalled the result register
//   holds, wave steps that produce and completing pixels wait; others still go.
module rgba8_box_mip_chain_core #(
    parameter int MAX_LOG2_WIDTH = rbmc_pkg::MAX_LOG2_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rbmc_pix_if.sink                     pix,
    rbmc_res_if.source                   res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rbmc_pkg::PADDR_W-1:0] paddr,
    input  logic [rbmc_pkg::PDATA_W-1:0] pwdata,
    output logic [rbmc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int MAXL = MAX_LOG2_WIDTH;
    localparam int LVW  = (MAXL > 1) ? $clog2(MAXL) : 1;

    // config
    logic [3:0] log2w_reg;
    logic [3:0] levels;
    logic       cfg_wr;

    // chain
    rbmc_pkg::cell_out_t co [MAXL];
    logic [MAXL-1:0]     take;
    logic [MAXL-1:0]     nxt_prod;
    rbmc_pkg::pix_t      in_pix;

    // wave: token walking the deeper cells
    logic                wave_valid_reg;
    logic                wave_valid_next;
    logic [LVW-1:0]      wave_lvl_reg;
    logic [LVW-1:0]      wave_lvl_next;
    rbmc_pkg::pix_t      wave_pix_reg;
    rbmc_pkg::pix_t      wave_pix_next;
    logic                wave_go;
    logic                wprod;

    // result register
    logic                out_valid_reg;
    logic [3:0]          out_level_reg;
    logic [10:0]         out_col_reg;
    logic [10:0]         out_row_reg;
    rbmc_pkg::pix_t      out_avg_reg;
    logic                out_final_reg;

    logic                emit_ok;
    logic                acc;
    logic                e0;
    logic                emit;
    logic [LVW-1:0]      e_idx;
    rbmc_pkg::cell_out_t esel;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rbmc_pkg::REG_LOG2_WIDTH);
    assign prdata = (paddr[2] == rbmc_pkg::REG_LOG2_WIDTH)
                    ? rbmc_pkg::PDATA_W'(log2w_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            log2w_reg <= rbmc_pkg::LOG2W_RESET;
        else if (cfg_wr)
            log2w_reg <= pwdata[3:0];
    end

    assign levels = (log2w_reg > 4'(MAXL)) ? 4'(MAXL) : log2w_reg;

    // level cells
    assign in_pix = {pix.alpha, pix.blue, pix.green, pix.red};

    generate
        for (genvar s = 0; s < MAXL; s++)
        begin : g_cell
            if (s == 0)
            begin : g_first
                rbmc_cell #(.MAXL(MAXL), .S(s)) u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .clr    (cfg_wr),
                    .take   (take[s]),
                    .levels (levels),
                    .pix    (in_pix),
                    .out    (co[s])
                );
                assign take[s] = acc;
            end
            else
            begin : g_deep
                rbmc_cell #(.MAXL(MAXL), .S(s)) u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .clr    (cfg_wr),
                    .take   (take[s]),
                    .levels (levels),
                    .pix    (wave_pix_reg),
                    .out    (co[s])
                );
                assign take[s] = wave_go && (wave_lvl_reg == LVW'(s));
            end
            // will the next level also complete: decides final_res
            if (s < MAXL - 1)
            begin : g_nxt
                assign nxt_prod[s] = co[s+1].prod;
            end
            else
            begin : g_last
                assign nxt_prod[s] = 1'b0;
            end
        end
    endgenerate

    // handshake and wave control
    assign emit_ok   = !out_valid_reg || res.ready;
    assign pix.ready = !co[0].prod || (!wave_valid_reg && emit_ok);
    assign acc       = pix.valid && pix.ready;
    assign wprod     = co[wave_lvl_reg].prod;
    assign wave_go   = wave_valid_reg && (!wprod || emit_ok);
    assign e0        = acc && co[0].prod;
    assign emit      = e0 || (wave_go && wprod);
    assign e_idx     = e0 ? '0 : wave_lvl_reg;
    assign esel      = co[e_idx];

    always_comb
    begin
        wave_valid_next = wave_valid_reg;
        wave_lvl_next   = wave_lvl_reg;
        wave_pix_next   = wave_pix_reg;
        if (e0)
        begin
            wave_valid_next = levels > 4'd1;
            wave_lvl_next   = LVW'(1);
            wave_pix_next   = co[0].avg;
        end
        else if (wave_go)
        begin
            wave_valid_next = wprod && ((5'(wave_lvl_reg) + 5'd1) < 5'(levels));
            wave_lvl_next   = wave_lvl_reg + 1'b1;
            wave_pix_next   = esel.avg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wave_valid_reg <= wave_valid_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_lvl_reg <= wave_lvl_next;
        wave_pix_reg <= wave_pix_next;
        if (emit)
        begin
            out_level_reg <= 4'(e_idx) + 4'd1;
            out_col_reg   <= esel.col;
            out_row_reg   <= esel.row;
            out_avg_reg   <= esel.avg;
            out_final_reg <= !nxt_prod[e_idx];
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.level     = out_level_reg;
    assign res.col       = out_col_reg;
    assign res.row       = out_row_reg;
    assign res.avg_red   = out_avg_reg[0];
    assign res.avg_green = out_avg_reg[1];
    assign res.avg_blue  = out_avg_reg[2];
    assign res.avg_alpha = out_avg_reg[3];
    assign res.final_res = out_final_reg;

endmodule

@@ sv/rbmc_checker.sv @@
// rbmc_checker: port-level assertions for the mip chain core, bound to it.
// Depends on rbmc_pkg and rgba8_box_mip_chain_core.
module rbmc_checker #(
    parameter int MAXL = rbmc_pkg::MAX_LOG2_WIDTH
) (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [3:0]  res_level,
    input logic [10:0] res_col,
    input logic [10:0] res_row,
    input logic        res_final
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_level) && $stable(res_col)
                                    && $stable(res_row))
        else $error("stalled result changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_level != 4'd0 && res_level <= 4'(MAXL))
        else $error("level out of range");

    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_final
        |=> res_valid && res_level == $past(res_level) + 4'd1)
        else $error("non-final result not followed by next level");

endmodule

bind rgba8_box_mip_chain_core rbmc_checker #(.MAXL(MAX_LOG2_WIDTH)) u_rbmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_level (res.level),
    .res_col   (res.col),
    .res_row   (res.row),
    .res_final (res.final_res)
);
